// File: hw/rtl/smx_pkg.sv
// Shared types, constants and opcodes of the stack machine executor.
// No dependencies.
package smx_pkg;

    localparam int MEM_WORDS   = 256;
    localparam int STACK_DEPTH = 64;
    localparam int MEM_AW      = $clog2(MEM_WORDS);
    localparam int STK_AW      = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);

    localparam logic [4:0] OP_PUSH   = 5'd0;
    localparam logic [4:0] OP_STORE  = 5'd1;
    localparam logic [4:0] OP_LOAD   = 5'd2;
    localparam logic [4:0] OP_SETLN  = 5'd3;
    localparam logic [4:0] OP_JUMP   = 5'd4;
    localparam logic [4:0] OP_JUMPIF = 5'd5;
    localparam logic [4:0] OP_HALT   = 5'd6;
    localparam logic [4:0] OP_NEXTLN = 5'd7;
    localparam logic [4:0] OP_WRI    = 5'd8;
    localparam logic [4:0] OP_WRS    = 5'd9;
    localparam logic [4:0] OP_WRLNI  = 5'd10;
    localparam logic [4:0] OP_WRLNS  = 5'd11;
    localparam logic [4:0] OP_READ   = 5'd12;
    localparam logic [4:0] OP_ADD    = 5'd13;
    localparam logic [4:0] OP_SUB    = 5'd14;
    localparam logic [4:0] OP_MUL    = 5'd15;
    localparam logic [4:0] OP_DIV    = 5'd16;
    localparam logic [4:0] OP_MOD    = 5'd17;
    localparam logic [4:0] OP_EQ     = 5'd18;
    localparam logic [4:0] OP_NE     = 5'd19;
    localparam logic [4:0] OP_GT     = 5'd20;
    localparam logic [4:0] OP_LT     = 5'd21;
    localparam logic [4:0] OP_GE     = 5'd22;
    localparam logic [4:0] OP_LE     = 5'd23;

    localparam logic [1:0] ST_CONT  = 2'd0;
    localparam logic [1:0] ST_HALT  = 2'd1;
    localparam logic [1:0] ST_STEP  = 2'd2;
    localparam logic [1:0] ST_FAULT = 2'd3;

    localparam logic [2:0] F_NONE  = 3'd0;
    localparam logic [2:0] F_OVER  = 3'd1;
    localparam logic [2:0] F_UNDER = 3'd2;
    localparam logic [2:0] F_ADDR  = 3'd3;
    localparam logic [2:0] F_JUMP  = 3'd4;
    localparam logic [2:0] F_DIVZ  = 3'd5;
    localparam logic [2:0] F_OPC   = 3'd6;

    localparam logic [1:0] PK_NONE = 2'd0;
    localparam logic [1:0] PK_INT  = 2'd1;
    localparam logic [1:0] PK_STR  = 2'd2;

    localparam logic CFG_STEP  = 1'b0;
    localparam logic CFG_LINES = 1'b1;

    typedef struct packed {
        logic [4:0]         command;
        logic signed [31:0] immediate;
        logic signed [31:0] read_value;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic [2:0]         fault_code;
        logic               jump_taken;
        logic [15:0]        jump_target;
        logic [1:0]         print_kind;
        logic signed [31:0] print_value;
        logic               print_newline;
        logic [15:0]        current_line;
        logic [SP_W-1:0]    stack_level;
        logic               step_halted;
    } t_out;

    typedef struct packed {
        logic cap;
        logic rd2;
        logic exe;
        logic ld_fin;
        logic div_step;
        logic div_fin;
    } t_ctl;

    typedef struct packed {
        logic go_load;
        logic go_div;
        logic div_last;
    } t_sts;

endpackage

// File: hw/rtl/smx_ctrl.sv
// Sequencer of the stack machine executor: steps one instruction through
// read, execute, memory or divide, and hand-off. Depends on smx_pkg.
module smx_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_free,
    input  smx_pkg::t_sts i_sts,
    output smx_pkg::t_ctl o_ctl,
    output logic          o_in_ready,
    output logic          o_push
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD2  = 3'd1;
    localparam logic [2:0] S_EXE  = 3'd2;
    localparam logic [2:0] S_MEM  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DWB  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_push  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.cap = 1'b1;
                    n_state   = S_RD2;
                end
            end
            S_RD2: begin
                o_ctl.rd2 = 1'b1;
                n_state   = S_EXE;
            end
            S_EXE: begin
                o_ctl.exe = 1'b1;
                if (i_sts.go_load) begin
                    n_state = S_MEM;
                end else if (i_sts.go_div) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_MEM: begin
                o_ctl.ld_fin = 1'b1;
                n_state      = S_FIN;
            end
            S_DIV: begin
                o_ctl.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_DWB;
                end
            end
            S_DWB: begin
                o_ctl.div_fin = 1'b1;
                n_state       = S_FIN;
            end
            S_FIN: begin
                if (i_out_free) begin
                    o_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

// File: hw/rtl/smx_dpath.sv
// Datapath of the stack machine executor: operand stack, data memory,
// configuration, ALU and serial divider. Depends on smx_pkg.
module smx_dpath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  smx_pkg::t_ctl i_ctl,
    input  smx_pkg::t_in  i_in,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [15:0]   i_cfg_data,
    output smx_pkg::t_sts o_sts,
    output smx_pkg::t_out o_res
);
    localparam int SP_W   = smx_pkg::SP_W;
    localparam int STK_AW = smx_pkg::STK_AW;
    localparam int MEM_AW = smx_pkg::MEM_AW;

    logic [31:0] r_stk [smx_pkg::STACK_DEPTH];
    logic [31:0] r_mem [smx_pkg::MEM_WORDS];
    logic [smx_pkg::MEM_WORDS-1:0] r_mem_vld;

    smx_pkg::t_in   r_in;
    smx_pkg::t_out  r_res, n_res;
    logic [31:0]     r_top, r_stk_rd, r_mem_rd;
    logic            r_mem_rv;
    logic [SP_W-1:0] r_sp, n_sp;
    logic [15:0]     r_line, n_line;
    logic            r_halt, n_halt;
    logic            r_step;
    logic [15:0]     r_plines;
    logic [STK_AW-1:0] r_wb_idx, n_wb_idx;

    logic [31:0] r_dq, r_dmb;
    logic [32:0] r_dr;
    logic [4:0]  r_dcnt;
    logic        r_dnq, r_dnr, r_dmod;

    logic [31:0] p, q, alu, ma, mb;
    logic [1:0]  need;
    logic        st_we, mem_we, go_load, go_div;
    logic [STK_AW-1:0] st_idx;
    logic [31:0] st_data;
    logic        addr_ok, tgt_ok;
    logic [32:0] d_sh, d_sub;
    logic [31:0] div_val;
    logic        w_en;
    logic [STK_AW-1:0] w_idx;
    logic [31:0] w_data;
    logic [STK_AW-1:0] rd_idx;
    logic [SP_W-1:0]   sp_m1, sp_m2;

    assign sp_m1 = r_sp - SP_W'(1);
    assign sp_m2 = r_sp - SP_W'(2);

    always_comb begin
        unique case (r_in.command)
            smx_pkg::OP_STORE, smx_pkg::OP_JUMPIF, smx_pkg::OP_ADD, smx_pkg::OP_SUB,
            smx_pkg::OP_MUL, smx_pkg::OP_DIV, smx_pkg::OP_MOD, smx_pkg::OP_EQ,
            smx_pkg::OP_NE, smx_pkg::OP_GT, smx_pkg::OP_LT, smx_pkg::OP_GE,
            smx_pkg::OP_LE: need = 2'd2;
            smx_pkg::OP_LOAD, smx_pkg::OP_JUMP, smx_pkg::OP_WRI, smx_pkg::OP_WRLNI,
            smx_pkg::OP_READ: need = 2'd1;
            default: need = 2'd0;
        endcase
    end

    assign q  = r_top;
    assign p  = (need == 2'd2) ? r_stk_rd : r_top;
    assign ma = p[31] ? (32'd0 - p) : p;
    assign mb = q[31] ? (32'd0 - q) : q;
    assign addr_ok = ({1'b0, p} < 33'(smx_pkg::MEM_WORDS));

    always_comb begin
        logic [31:0] tgt;
        tgt    = p;
        tgt_ok = !tgt[31] && (tgt != 32'd0) && (tgt < {16'd0, r_plines});
        unique case (r_in.command)
            smx_pkg::OP_ADD: alu = p + q;
            smx_pkg::OP_SUB: alu = p - q;
            smx_pkg::OP_MUL: alu = p * q;
            smx_pkg::OP_EQ:  alu = {31'd0, p == q};
            smx_pkg::OP_NE:  alu = {31'd0, p != q};
            smx_pkg::OP_GT:  alu = {31'd0, $signed(q) < $signed(p)};
            smx_pkg::OP_LT:  alu = {31'd0, $signed(p) < $signed(q)};
            smx_pkg::OP_GE:  alu = {31'd0, !($signed(p) < $signed(q))};
            smx_pkg::OP_LE:  alu = {31'd0, !($signed(q) < $signed(p))};
            default:         alu = 32'd0;
        endcase
    end

    always_comb begin
        n_res        = r_res;
        n_res.status = smx_pkg::ST_CONT;
        n_res.fault_code    = smx_pkg::F_NONE;
        n_res.jump_taken    = 1'b0;
        n_res.jump_target   = 16'd0;
        n_res.print_kind    = smx_pkg::PK_NONE;
        n_res.print_value   = 32'sd0;
        n_res.print_newline = 1'b0;
        n_sp     = r_sp;
        n_line   = r_line;
        n_halt   = r_halt;
        st_we    = 1'b0;
        st_idx   = r_sp[STK_AW-1:0];
        st_data  = r_in.immediate;
        mem_we   = 1'b0;
        go_load  = 1'b0;
        go_div   = 1'b0;
        n_wb_idx = sp_m1[STK_AW-1:0];
        if (r_in.command > smx_pkg::OP_LE) begin
            n_res.fault_code = smx_pkg::F_OPC;
        end else if (r_sp < SP_W'(need)) begin
            n_res.fault_code = smx_pkg::F_UNDER;
        end else begin
            unique case (r_in.command)
                smx_pkg::OP_PUSH, smx_pkg::OP_NEXTLN: begin
                    if (r_sp >= SP_W'(smx_pkg::STACK_DEPTH)) begin
                        n_res.fault_code = smx_pkg::F_OVER;
                    end else begin
                        st_we   = 1'b1;
                        st_data = (r_in.command == smx_pkg::OP_PUSH) ? r_in.immediate
                                  : ({16'd0, r_line} + 32'd1);
                        n_sp    = r_sp + SP_W'(1);
                    end
                end
                smx_pkg::OP_STORE, smx_pkg::OP_READ: begin
                    if (!addr_ok) begin
                        n_res.fault_code = smx_pkg::F_ADDR;
                    end else begin
                        mem_we = 1'b1;
                        n_sp   = (r_in.command == smx_pkg::OP_STORE) ? sp_m2 : sp_m1;
                    end
                end
                smx_pkg::OP_LOAD: begin
                    if (!addr_ok) begin
                        n_res.fault_code = smx_pkg::F_ADDR;
                    end else begin
                        go_load = 1'b1;
                    end
                end
                smx_pkg::OP_SETLN: begin
                    n_line = r_in.immediate[15:0];
                    if (r_step && (r_in.immediate > 32'sd1)) begin
                        n_res.status = smx_pkg::ST_STEP;
                    end
                end
                smx_pkg::OP_JUMP, smx_pkg::OP_JUMPIF: begin
                    if (!tgt_ok) begin
                        n_res.fault_code = smx_pkg::F_JUMP;
                    end else begin
                        n_sp = r_sp - SP_W'(need);
                        if ((r_in.command == smx_pkg::OP_JUMP) || (q != 32'd0)) begin
                            n_res.jump_taken  = 1'b1;
                            n_res.jump_target = p[15:0];
                            if (r_step) begin
                                n_line       = p[15:0];
                                n_res.status = smx_pkg::ST_STEP;
                            end
                        end
                    end
                end
                smx_pkg::OP_HALT: begin
                    n_res.status = smx_pkg::ST_HALT;
                    n_halt       = r_halt | r_step;
                end
                smx_pkg::OP_WRI, smx_pkg::OP_WRLNI: begin
                    n_sp                = sp_m1;
                    n_res.print_kind    = smx_pkg::PK_INT;
                    n_res.print_value   = p;
                    n_res.print_newline = (r_in.command == smx_pkg::OP_WRLNI) | r_step;
                end
                smx_pkg::OP_WRS, smx_pkg::OP_WRLNS: begin
                    n_res.print_kind    = smx_pkg::PK_STR;
                    n_res.print_newline = (r_in.command == smx_pkg::OP_WRLNS) | r_step;
                end
                smx_pkg::OP_DIV, smx_pkg::OP_MOD: begin
                    if (q == 32'd0) begin
                        n_res.fault_code = smx_pkg::F_DIVZ;
                    end else begin
                        go_div   = 1'b1;
                        n_sp     = sp_m1;
                        n_wb_idx = sp_m2[STK_AW-1:0];
                    end
                end
                default: begin
                    st_we   = 1'b1;
                    st_idx  = sp_m2[STK_AW-1:0];
                    st_data = alu;
                    n_sp    = sp_m1;
                end
            endcase
        end
        if (n_res.fault_code != smx_pkg::F_NONE) begin
            n_res.status = smx_pkg::ST_FAULT;
            n_sp    = '0;
            n_line  = r_line;
            st_we   = 1'b0;
            mem_we  = 1'b0;
            go_load = 1'b0;
            go_div  = 1'b0;
        end
        n_res.current_line = n_line;
        n_res.stack_level  = n_sp;
        n_res.step_halted  = n_halt;
    end

    assign o_sts.go_load  = go_load;
    assign o_sts.go_div   = go_div;
    assign o_sts.div_last = (r_dcnt == 5'd31);
    assign o_res = r_res;

    assign d_sh  = {r_dr[31:0], r_dq[31]};
    assign d_sub = d_sh - {1'b0, r_dmb};
    assign div_val = r_dmod ? (r_dnr ? (32'd0 - r_dr[31:0]) : r_dr[31:0])
                            : (r_dnq ? (32'd0 - r_dq) : r_dq);

    always_comb begin
        priority if (i_ctl.ld_fin) begin
            w_en   = 1'b1;
            w_idx  = r_wb_idx;
            w_data = r_mem_rv ? r_mem_rd : 32'd0;
        end else if (i_ctl.div_fin) begin
            w_en   = 1'b1;
            w_idx  = r_wb_idx;
            w_data = div_val;
        end else begin
            w_en   = i_ctl.exe & st_we;
            w_idx  = st_idx;
            w_data = st_data;
        end
    end

    assign rd_idx = i_ctl.cap ? sp_m1[STK_AW-1:0] : sp_m2[STK_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_stk[w_idx] <= w_data;
        end
        r_stk_rd <= r_stk[rd_idx];
        if (i_ctl.exe && mem_we) begin
            r_mem[p[MEM_AW-1:0]] <= (r_in.command == smx_pkg::OP_STORE) ? q
                                    : r_in.read_value;
        end
        r_mem_rd <= r_mem[p[MEM_AW-1:0]];
        r_mem_rv <= r_mem_vld[p[MEM_AW-1:0]];
        if (i_ctl.cap) begin
            r_in <= i_in;
        end
        if (i_ctl.rd2) begin
            r_top <= r_stk_rd;
        end
        if (i_ctl.exe) begin
            r_res    <= n_res;
            r_wb_idx <= n_wb_idx;
            r_dq     <= ma;
            r_dmb    <= mb;
            r_dr     <= '0;
            r_dnq    <= p[31] ^ q[31];
            r_dnr    <= p[31];
            r_dmod   <= (r_in.command == smx_pkg::OP_MOD);
        end
        if (i_ctl.div_step) begin
            if (!d_sub[32]) begin
                r_dr <= d_sub;
                r_dq <= {r_dq[30:0], 1'b1};
            end else begin
                r_dr <= d_sh;
                r_dq <= {r_dq[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
            r_sp      <= '0;
            r_line    <= 16'd1;
            r_halt    <= 1'b0;
            r_step    <= 1'b0;
            r_plines  <= 16'd1;
            r_dcnt    <= '0;
        end else begin
            if (i_ctl.exe) begin
                r_sp   <= n_sp;
                r_line <= n_line;
                r_halt <= n_halt;
                r_dcnt <= '0;
                if (mem_we) begin
                    r_mem_vld[p[MEM_AW-1:0]] <= 1'b1;
                end
            end
            if (i_ctl.div_step) begin
                r_dcnt <= r_dcnt + 5'd1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    smx_pkg::CFG_STEP:  r_step   <= i_cfg_data[0];
                    smx_pkg::CFG_LINES: r_plines <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end
endmodule

// File: hw/rtl/stack_machine_executor_unit.sv
// Top level of the stack machine executor: controller, datapath and the
// output register. Depends on smx_pkg, smx_ctrl and smx_dpath.
//
// Executes one instruction per input transfer and returns one result per
// instruction. An instruction goes from acceptance to a result in the output
// register through stack read, second stack read, execute and hand-off; a
// load adds a registered data memory read, and divide or modulo add the
// one-bit-a-cycle divider and its write-back. The next instruction is
// accepted as soon as the result is loaded, even while it waits to be taken.
module stack_machine_executor_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  smx_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output smx_pkg::t_out o_data,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [15:0]   i_cfg_data
);
    smx_pkg::t_ctl ctl;
    smx_pkg::t_sts sts;
    smx_pkg::t_out res;
    logic          push;
    logic          r_ovalid;
    smx_pkg::t_out r_odata;

    smx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_out_free (!r_ovalid || i_ready),
        .i_sts      (sts),
        .o_ctl      (ctl),
        .o_in_ready (o_ready),
        .o_push     (push)
    );

    smx_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_in       (i_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_sts      (sts),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (push) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_odata <= res;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
endmodule
